[hdl/pcrt_pkg.sv]
// shared types and constants for the ycc row triple to rgb converter
package pcrt_pkg;

  // field widths
  localparam int POS_W  = 12;
  localparam int BAND_W = 8;
  localparam int ROW_W  = 9;
  localparam int COL_W  = 10;
  localparam int K_W    = 9;
  localparam int PIX_W  = 8;
  localparam int MODE_W = 2;

  // resolution mode codes, anything above full size acts as full size
  localparam logic [MODE_W-1:0] MODE_BASE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MID  = 2'd1;

  // smallest image width
  localparam int BASE_WIDTH = 192;

  // color matrix coefficients, scaled by 1e7
  localparam logic        [15:0] K_Y  = 16'd54980;
  localparam logic signed [17:0] K_RR = 18'sd51681;
  localparam logic signed [17:0] K_GB = 18'sd15446;
  localparam logic signed [17:0] K_GR = 18'sd26325;
  localparam logic signed [17:0] K_BB = 18'sd79533;

  // chroma offsets
  localparam logic signed [9:0] OFS_CB = 10'sd156;
  localparam logic signed [9:0] OFS_CR = 10'sd137;

  // sums at or above this give full scale (2*s/78125 >= 256)
  localparam logic signed [27:0] SAT_LIMIT = 28'sd10000000;

  // exact floor(x/78125) for x below 2^25: (x * RECIP) >> RECIP_SHIFT
  localparam logic [25:0] RECIP       = 26'd56294996;
  localparam int          RECIP_SHIFT = 42;

  // one issued row memory read and what travels with it
  typedef struct packed {
    logic             valid;
    logic             rsel;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [PIX_W-1:0] cr;
    logic             last;
    logic             done;
  } tag_t;

  // one finished pixel
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last;
    logic             done;
  } pixel_t;

endpackage

[hdl/photo_cd_row_triple_to_rgb.sv]
// top level of the ycc 4:2:0 row triple to rgb converter
//
// Input: data_valid / data_stall / data_byte carry the image bytes band by
// band: a luma row, a second luma row, the Cb half row and the Cr half row.
// Luma and Cb bytes fill the row buffers, one transfer per unstalled cycle.
// Each Cr byte yields four pixels on pixel_valid / pixel_stall: the even row
// at columns 2k and 2k+1, then the odd row at the same columns, with
// last_of_run on the fourth and image_done on the final pixel of the image.
// A Cr byte holds the input until its last read is issued, with one read
// of the luma row buffer per pixel, so the sustained rate is one pixel per
// cycle while the output is not stalled.
// cfg_valid / cfg_ready / resolution_mode set the image size and restart
// the stream at the first byte of a band; write it only while idle.
// Reset selects the smallest size and the start of an image; the row
// buffers need no clearing pass since every entry is written before use.
// A stalled output is held in an output register plus a skid stage; once
// the skid stage fills, data_stall rises until the output moves again.
module photo_cd_row_triple_to_rgb #(
  parameter int MAX_WIDTH = 768
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcrt_pkg::MODE_W-1:0]       resolution_mode,
  input  logic                              data_valid,
  output logic                              data_stall,
  input  logic [pcrt_pkg::PIX_W-1:0]        data_byte,
  output logic                              pixel_valid,
  input  logic                              pixel_stall,
  output logic [pcrt_pkg::ROW_W-1:0]        pixel_row,
  output logic [pcrt_pkg::COL_W-1:0]        pixel_column,
  output logic [pcrt_pkg::PIX_W-1:0]        red,
  output logic [pcrt_pkg::PIX_W-1:0]        green,
  output logic [pcrt_pkg::PIX_W-1:0]        blue,
  output logic                              last_of_run,
  output logic                              image_done
);

  localparam int LW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH / 2);

  logic                       adv;
  logic                       luma1_we;
  logic                       luma2_we;
  logic                       cb_we;
  logic [LW-1:0]              luma_wr_addr;
  logic [CW-1:0]              cb_wr_addr;
  logic [pcrt_pkg::PIX_W-1:0] wr_data;
  logic                       rd_en;
  logic [LW-1:0]              luma_rd_addr;
  logic [CW-1:0]              cb_rd_addr;
  logic [pcrt_pkg::PIX_W-1:0] luma1_q;
  logic [pcrt_pkg::PIX_W-1:0] luma2_q;
  logic [pcrt_pkg::PIX_W-1:0] cb_q;
  pcrt_pkg::tag_t             rd_tag;
  pcrt_pkg::pixel_t           pixel;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // stream control and read sequencer
  pcrt_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (resolution_mode),
    .data_valid  (data_valid),
    .data_byte   (data_byte),
    .data_stall  (data_stall),
    .adv         (adv),
    .luma1_we    (luma1_we),
    .luma2_we    (luma2_we),
    .luma_wr_addr(luma_wr_addr),
    .cb_we       (cb_we),
    .cb_wr_addr  (cb_wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .luma_rd_addr(luma_rd_addr),
    .cb_rd_addr  (cb_rd_addr),
    .rd_tag      (rd_tag)
  );

  // even luma row buffer
  pcrt_ram #(
    .WIDTH(pcrt_pkg::PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_luma1 (
    .clk    (clk),
    .wr_en  (luma1_we),
    .wr_addr(luma_wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(luma_rd_addr),
    .rd_data(luma1_q)
  );

  // odd luma row buffer
  pcrt_ram #(
    .WIDTH(pcrt_pkg::PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_luma2 (
    .clk    (clk),
    .wr_en  (luma2_we),
    .wr_addr(luma_wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(luma_rd_addr),
    .rd_data(luma2_q)
  );

  // Cb half row buffer
  pcrt_ram #(
    .WIDTH(pcrt_pkg::PIX_W),
    .DEPTH(MAX_WIDTH / 2)
  ) u_cb (
    .clk    (clk),
    .wr_en  (cb_we),
    .wr_addr(cb_wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(cb_rd_addr),
    .rd_data(cb_q)
  );

  // color conversion and output stage
  pcrt_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .rd_tag     (rd_tag),
    .luma1_q    (luma1_q),
    .luma2_q    (luma2_q),
    .cb_q       (cb_q),
    .pixel_stall(pixel_stall),
    .adv        (adv),
    .pixel_valid(pixel_valid),
    .pixel      (pixel)
  );

  // pixel fields
  assign pixel_row    = pixel.row;
  assign pixel_column = pixel.column;
  assign red          = pixel.red;
  assign green        = pixel.green;
  assign blue         = pixel.blue;
  assign last_of_run  = pixel.last;
  assign image_done   = pixel.done;

endmodule

[hdl/pcrt_ram.sv]
// generic simple dual port ram with registered read
module pcrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/pcrt_ctrl.sv]
// stream position tracking, row buffer writes and the four-read pixel sequencer
module pcrt_ctrl #(
  parameter int MAX_WIDTH = 768
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [pcrt_pkg::MODE_W-1:0]       cfg_data,
  input  logic                              data_valid,
  input  logic [pcrt_pkg::PIX_W-1:0]        data_byte,
  output logic                              data_stall,
  input  logic                              adv,
  output logic                              luma1_we,
  output logic                              luma2_we,
  output logic [$clog2(MAX_WIDTH)-1:0]      luma_wr_addr,
  output logic                              cb_we,
  output logic [$clog2(MAX_WIDTH/2)-1:0]    cb_wr_addr,
  output logic [pcrt_pkg::PIX_W-1:0]        wr_data,
  output logic                              rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]      luma_rd_addr,
  output logic [$clog2(MAX_WIDTH/2)-1:0]    cb_rd_addr,
  output pcrt_pkg::tag_t                    rd_tag
);

  localparam int LW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH / 2);
  localparam int PW = pcrt_pkg::POS_W;

  // image widths per mode after fitting into the row buffers
  localparam int W0 = pcrt_pkg::BASE_WIDTH;
  localparam int W1 = (2 * W0 > MAX_WIDTH) ? W0 : 2 * W0;
  localparam int W2 = (4 * W0 > MAX_WIDTH) ? W1 : 4 * W0;

  // last band index per mode
  localparam int B0M = W0 / 3 - 1;
  localparam int B1M = W1 / 3 - 1;
  localparam int B2M = W2 / 3 - 1;

  logic [pcrt_pkg::MODE_W-1:0] mode;
  logic [PW-1:0]               pos;
  logic [pcrt_pkg::BAND_W-1:0] band;
  logic                        seq_active;
  logic [1:0]                  seq_n;
  logic [pcrt_pkg::K_W-1:0]    seq_k;
  logic [pcrt_pkg::PIX_W-1:0]  seq_cr;
  logic [pcrt_pkg::BAND_W-1:0] seq_band;
  logic                        seq_done;

  logic [PW-1:0]               w;
  logic [PW-1:0]               half;
  logic [PW-1:0]               two_w;
  logic [PW-1:0]               cr_start;
  logic [PW-1:0]               pos_e;
  logic [pcrt_pkg::BAND_W-1:0] bands_m1;
  logic [PW-1:0]               l2_off;
  logic [PW-1:0]               cb_off;
  logic [PW-1:0]               k_off;
  logic                        is_l1;
  logic                        is_l2;
  logic                        is_cb;
  logic                        is_cr;
  logic                        k_last;
  logic                        band_done;
  logic                        in_fire;

  // geometry of the current mode
  always_comb begin
    unique case (mode)
      pcrt_pkg::MODE_BASE: begin
        w        = PW'(W0);
        bands_m1 = pcrt_pkg::BAND_W'(B0M);
      end
      pcrt_pkg::MODE_MID: begin
        w        = PW'(W1);
        bands_m1 = pcrt_pkg::BAND_W'(B1M);
      end
      default: begin
        w        = PW'(W2);
        bands_m1 = pcrt_pkg::BAND_W'(B2M);
      end
    endcase
  end

  assign half     = w >> 1;
  assign two_w    = w << 1;
  assign cr_start = two_w + half;
  assign pos_e    = (pos >= two_w + w) ? '0 : pos;
  assign l2_off   = pos_e - w;
  assign cb_off   = pos_e - two_w;
  assign k_off    = pos_e - cr_start;

  // which part of the band the next byte belongs to
  always_comb begin
    is_l1 = 1'b0;
    is_l2 = 1'b0;
    is_cb = 1'b0;
    is_cr = 1'b0;
    priority if (pos_e < w) begin
      is_l1 = 1'b1;
    end else if (pos_e < two_w) begin
      is_l2 = 1'b1;
    end else if (pos_e < cr_start) begin
      is_cb = 1'b1;
    end else begin
      is_cr = 1'b1;
    end
  end

  assign k_last    = (k_off == half - 1'b1);
  assign band_done = k_last && (band >= bands_m1);

  // a cr byte holds the input until its last read goes out
  assign data_stall = !adv || (seq_active && (seq_n != 2'd3));
  assign in_fire    = data_valid && !data_stall;

  // row buffer writes
  assign luma1_we     = in_fire && is_l1;
  assign luma2_we     = in_fire && is_l2;
  assign cb_we        = in_fire && is_cb;
  assign luma_wr_addr = is_l1 ? pos_e[LW-1:0] : l2_off[LW-1:0];
  assign cb_wr_addr   = cb_off[CW-1:0];
  assign wr_data      = data_byte;

  // position, band and sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= pcrt_pkg::MODE_BASE;
      pos        <= '0;
      band       <= '0;
      seq_active <= 1'b0;
      seq_n      <= '0;
    end else begin
      if (cfg_valid) begin
        mode <= cfg_data;
        pos  <= '0;
        band <= '0;
      end else if (in_fire) begin
        if (is_cr && k_last) begin
          pos  <= '0;
          band <= band_done ? '0 : band + 1'b1;
        end else begin
          pos <= pos_e + 1'b1;
        end
      end
      // a new cr byte restarts the sequence as the previous one ends
      if (in_fire && is_cr) begin
        seq_active <= 1'b1;
        seq_n      <= '0;
      end else if (seq_active && adv) begin
        seq_n <= seq_n + 1'b1;
        if (seq_n == 2'd3) begin
          seq_active <= 1'b0;
        end
      end
    end
  end

  // payload of the cr byte being worked on
  always_ff @(posedge clk) begin
    if (in_fire && is_cr) begin
      seq_k    <= k_off[pcrt_pkg::K_W-1:0];
      seq_cr   <= data_byte;
      seq_band <= band;
      seq_done <= band_done;
    end
  end

  // one luma read per pixel, even row first, then odd row
  always_comb begin
    rd_tag.valid  = seq_active;
    rd_tag.rsel   = seq_n[1];
    rd_tag.row    = {seq_band, seq_n[1]};
    rd_tag.column = {seq_k, seq_n[0]};
    rd_tag.cr     = seq_cr;
    rd_tag.last   = (seq_n == 2'd3);
    rd_tag.done   = seq_done && (seq_n == 2'd3);
  end

  assign rd_en        = seq_active && adv;
  assign luma_rd_addr = rd_tag.column[LW-1:0];
  assign cb_rd_addr   = seq_k[CW-1:0];

endmodule

[hdl/pcrt_conv.sv]
// color matrix pipeline with exact scaling, clamping and output skid buffer
module pcrt_conv (
  input  logic                       clk,
  input  logic                       rst,
  input  pcrt_pkg::tag_t             rd_tag,
  input  logic [pcrt_pkg::PIX_W-1:0] luma1_q,
  input  logic [pcrt_pkg::PIX_W-1:0] luma2_q,
  input  logic [pcrt_pkg::PIX_W-1:0] cb_q,
  input  logic                       pixel_stall,
  output logic                       adv,
  output logic                       pixel_valid,
  output pcrt_pkg::pixel_t           pixel
);

  typedef struct packed {
    logic        zero;
    logic        sat;
    logic [24:0] x;
  } chan_t;

  // clamp flags and doubled sum of one channel
  function automatic chan_t chan_prep(input logic signed [27:0] s);
    chan_t c;
    c.zero = s[27] || (s == '0);
    c.sat  = (s >= pcrt_pkg::SAT_LIMIT);
    c.x    = {s[23:0], 1'b0};
    return c;
  endfunction

  // floor(x/78125) by reciprocal, then clamp
  function automatic logic [7:0] chan_value(input chan_t c);
    logic [50:0] p;
    p = 51'(c.x) * 51'(pcrt_pkg::RECIP);
    if (c.zero) begin
      return 8'd0;
    end
    if (c.sat) begin
      return 8'd255;
    end
    return p[pcrt_pkg::RECIP_SHIFT+7:pcrt_pkg::RECIP_SHIFT];
  endfunction

  logic                    v1, v2, v3, v4;
  pcrt_pkg::tag_t          tag1, tag2, tag3;
  logic [23:0]             py;
  logic signed [27:0]      prr, pgb, pgr, pbb;
  chan_t                   cr3, cg3, cb3;
  pcrt_pkg::pixel_t        s4_pix;
  pcrt_pkg::pixel_t        skid_pix;
  logic                    skid_full;

  logic [7:0]              y;
  logic signed [9:0]       db, dr;
  logic signed [27:0]      sr, sg, sb;

  // the pipeline moves while the skid stage is free
  assign adv = !skid_full;

  // stage one inputs: luma row select and chroma differences
  assign y  = tag1.rsel ? luma2_q : luma1_q;
  assign db = $signed({2'b00, cb_q}) - pcrt_pkg::OFS_CB;
  assign dr = $signed({2'b00, tag1.cr}) - pcrt_pkg::OFS_CR;

  // stage two sums
  assign sr = $signed({4'b0000, py}) + prr;
  assign sg = $signed({4'b0000, py}) - pgb - pgr;
  assign sb = $signed({4'b0000, py}) + pbb;

  // valid bits and output handshake control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      v4          <= 1'b0;
      pixel_valid <= 1'b0;
      skid_full   <= 1'b0;
    end else begin
      if (adv) begin
        v1 <= rd_tag.valid;
        v2 <= v1;
        v3 <= v2;
        v4 <= v3;
      end
      if (!pixel_valid || !pixel_stall) begin
        pixel_valid <= skid_full || (v4 && adv);
        skid_full   <= 1'b0;
      end else if (v4 && adv) begin
        skid_full <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      tag1 <= rd_tag;
      // products
      tag2 <= tag1;
      py   <= 24'(y) * pcrt_pkg::K_Y;
      prr  <= 28'(dr) * pcrt_pkg::K_RR;
      pgb  <= 28'(db) * pcrt_pkg::K_GB;
      pgr  <= 28'(dr) * pcrt_pkg::K_GR;
      pbb  <= 28'(db) * pcrt_pkg::K_BB;
      // sums and clamp flags
      tag3 <= tag2;
      cr3  <= chan_prep(sr);
      cg3  <= chan_prep(sg);
      cb3  <= chan_prep(sb);
      // scaled components
      s4_pix.row    <= tag3.row;
      s4_pix.column <= tag3.column;
      s4_pix.red    <= chan_value(cr3);
      s4_pix.green  <= chan_value(cg3);
      s4_pix.blue   <= chan_value(cb3);
      s4_pix.last   <= tag3.last;
      s4_pix.done   <= tag3.done;
    end
    // output register and skid
    if (!pixel_valid || !pixel_stall) begin
      pixel <= skid_full ? skid_pix : s4_pix;
    end else if (adv) begin
      skid_pix <= s4_pix;
    end
  end

endmodule

[verif/photo_cd_row_triple_to_rgb_tb.sv]
// self-checking testbench for the ycc 4:2:0 row triple to rgb converter
`timescale 1ns / 100ps

module photo_cd_row_triple_to_rgb_tb;

  localparam int MAX_W = 768;
  localparam logic [pcrt_pkg::MODE_W-1:0] MODE_FULL = 2'd2;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER_PIXELS = 24;

  // expected pixels worked out from the byte stream
  class pixel_scoreboard;
    logic [pcrt_pkg::MODE_W-1:0] mode;
    logic [7:0] luma_even [MAX_W];
    logic [7:0] luma_odd [MAX_W];
    logic [7:0] cb_half [MAX_W/2];
    int unsigned byte_pos;
    int unsigned band;
    pcrt_pkg::pixel_t expected_q [$];
    int unsigned failures;
    int unsigned checked;

    function new();
      mode = pcrt_pkg::MODE_BASE;
      byte_pos = 0;
      band = 0;
      failures = 0;
      checked = 0;
    endfunction

    // a register write restarts the image
    function void set_mode(logic [pcrt_pkg::MODE_W-1:0] m);
      mode = m;
      byte_pos = 0;
      band = 0;
    endfunction

    function int unsigned row_width();
      int unsigned w;
      w = (mode >= MODE_FULL) ? pcrt_pkg::BASE_WIDTH * 4 : pcrt_pkg::BASE_WIDTH << mode;
      while (w > MAX_W && w > pcrt_pkg::BASE_WIDTH) w = w >> 1;
      return w;
    endfunction

    // truncate 2*s/78125 toward zero, clamp to a byte
    static function logic [7:0] scale_clamp(longint s);
      longint q;
      if (s <= 0) return 8'd0;
      q = (2 * s) / 78125;
      return (q > 255) ? 8'd255 : 8'(q);
    endfunction

    function void note_byte(logic [7:0] d);
      int unsigned w, half, bands, p, k, r, c;
      bit done;
      longint y, db, dr;
      pcrt_pkg::pixel_t px;
      w = row_width();
      half = w / 2;
      bands = (w * 2 / 3) / 2;
      p = (byte_pos >= 3 * w) ? 0 : byte_pos;
      // luma rows and cb half are only stored
      if (p < w) begin
        luma_even[p] = d;
        byte_pos = p + 1;
        return;
      end
      if (p < 2 * w) begin
        luma_odd[p - w] = d;
        byte_pos = p + 1;
        return;
      end
      if (p < 2 * w + half) begin
        cb_half[p - 2 * w] = d;
        byte_pos = p + 1;
        return;
      end
      // cr byte: two columns of both rows
      k = p - 2 * w - half;
      done = (k == half - 1) && (band >= bands - 1);
      db = longint'(cb_half[k]) - 156;
      dr = longint'(d) - 137;
      for (int n = 0; n < 4; n++) begin
        r = n >> 1;
        c = 2 * k + (n & 1);
        y = r ? longint'(luma_odd[c]) : longint'(luma_even[c]);
        px.row = pcrt_pkg::ROW_W'(2 * band + r);
        px.column = pcrt_pkg::COL_W'(c);
        px.red = scale_clamp(54980 * y + 51681 * dr);
        px.green = scale_clamp(54980 * y - 15446 * db - 26325 * dr);
        px.blue = scale_clamp(54980 * y + 79533 * db);
        px.last = (n == 3);
        px.done = (n == 3) && done;
        expected_q.push_back(px);
      end
      if (k == half - 1) begin
        byte_pos = 0;
        band = done ? 0 : ((band + 1) & 8'hFF);
      end else begin
        byte_pos = p + 1;
      end
    endfunction

    function void check_pixel(pcrt_pkg::pixel_t got);
      pcrt_pkg::pixel_t exp_px;
      checked++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected pixel: row %0d col %0d rgb %0d %0d %0d",
                   got.row, got.column, got.red, got.green, got.blue);
        return;
      end
      exp_px = expected_q.pop_front();
      if (got.row !== exp_px.row || got.column !== exp_px.column ||
          got.red !== exp_px.red || got.green !== exp_px.green ||
          got.blue !== exp_px.blue || got.last !== exp_px.last ||
          got.done !== exp_px.done) begin
        failures++;
        if (failures <= 10)
          $display("pixel mismatch: expected r%0d c%0d rgb %0d %0d %0d last %0b done %0b,",
                   exp_px.row, exp_px.column, exp_px.red, exp_px.green, exp_px.blue,
                   exp_px.last, exp_px.done,
                   " got r%0d c%0d rgb %0d %0d %0d last %0b done %0b",
                   got.row, got.column, got.red, got.green, got.blue,
                   got.last, got.done);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pcrt_pkg::MODE_W-1:0] resolution_mode = pcrt_pkg::MODE_BASE;
  logic data_valid = 1'b0;
  logic data_stall;
  logic [pcrt_pkg::PIX_W-1:0] data_byte = '0;
  logic pixel_valid;
  logic pixel_stall = 1'b0;
  logic [pcrt_pkg::ROW_W-1:0] pixel_row;
  logic [pcrt_pkg::COL_W-1:0] pixel_column;
  logic [pcrt_pkg::PIX_W-1:0] red;
  logic [pcrt_pkg::PIX_W-1:0] green;
  logic [pcrt_pkg::PIX_W-1:0] blue;
  logic last_of_run;
  logic image_done;

  pixel_scoreboard sb;
  pcrt_pkg::pixel_t seen_pixel;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic hold_off = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned pixels_seen = 0;
  logic [7:0] corner_values [8] = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd137, 8'd156,
                                    8'd128, 8'd127};

  photo_cd_row_triple_to_rgb dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .resolution_mode(resolution_mode),
    .data_valid(data_valid),
    .data_stall(data_stall),
    .data_byte(data_byte),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_row(pixel_row),
    .pixel_column(pixel_column),
    .red(red),
    .green(green),
    .blue(blue),
    .last_of_run(last_of_run),
    .image_done(image_done)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // random receiver stall, plus the long hold-off
  always @(posedge clk) begin
    pixel_stall <= hold_off || ($urandom_range(99, 0) < recv_idle_pct);
  end

  // watch both channels: pixels are checked before the byte is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && !pixel_stall) begin
        seen_pixel.row = pixel_row;
        seen_pixel.column = pixel_column;
        seen_pixel.red = red;
        seen_pixel.green = green;
        seen_pixel.blue = blue;
        seen_pixel.last = last_of_run;
        seen_pixel.done = image_done;
        sb.check_pixel(seen_pixel);
        pixels_seen++;
      end
      if (data_valid && !data_stall) begin
        sb.note_byte(data_byte);
        bytes_sent++;
      end
    end
  end

  // long receiver hold-off so the output buffers fill and the input stalls
  initial begin
    while (pixels_seen < HOLD_AFTER_PIXELS) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic set_idle(input int unsigned sender_pct, input int unsigned receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  // one byte transfer, with random gaps in front
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (data_stall);
  endtask

  // corner values spread over the band so that every cb/cr pair shows up
  function automatic logic [7:0] pick_byte(int unsigned i, int unsigned w, bit directed);
    int unsigned p, half;
    p = i % (3 * w);
    half = w / 2;
    if (!directed)
      return ($urandom_range(3, 0) == 0) ? corner_values[$urandom_range(7, 0)]
                                         : 8'($urandom_range(255, 0));
    if (p < w) return corner_values[(p / 2 + 3) % 8];
    if (p < 2 * w) return corner_values[((p - w) / 2 * 3 + 5) % 8];
    if (p < 2 * w + half) return corner_values[((p - 2 * w) / 8) % 8];
    return corner_values[(p - 2 * w - half) % 8];
  endfunction

  // bytes at band positions first .. first+count-1, valid stays up at the end
  task automatic send_stream(input int unsigned first, input int unsigned count,
                             input bit directed);
    int unsigned w;
    w = sb.row_width();
    for (int unsigned i = first; i < first + count; i++)
      send_byte(pick_byte(i, w, directed));
  endtask

  // drain, then give trailing stored bytes time to settle
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mode(input logic [pcrt_pkg::MODE_W-1:0] m);
    cfg_valid <= 1'b1;
    resolution_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_mode(m);
  endtask

  // main sequence
  initial begin
    int unsigned w, split_a, split_b;
    sb = new();
    set_idle(7, 48);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // one band at the smallest size; idle profiles change along the cr half row
    write_mode(pcrt_pkg::MODE_BASE);
    w = sb.row_width();
    split_a = 2 * w + w / 2 + w / 6;
    split_b = split_a + w / 6;
    send_stream(0, split_a, 1'b1);
    set_idle(48, 7);
    send_stream(split_a, split_b - split_a, 1'b0);
    set_idle(0, 0);
    send_stream(split_b, 3 * w - split_b, 1'b0);
    data_valid <= 1'b0;
    wait_idle();

    $display("run covered %0d byte transfers of one band at the smallest size, %0d pixels checked",
             bytes_sent, pixels_seen);
    $display("three sender/receiver idle mixes over the cr half row, one long output hold-off");
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d failing pixel transfer(s), %0d pixel(s) still pending",
               sb.failures, sb.pending());
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/pcrt_pkg.sv
hdl/pcrt_ram.sv
hdl/pcrt_ctrl.sv
hdl/pcrt_conv.sv
hdl/photo_cd_row_triple_to_rgb.sv
verif/photo_cd_row_triple_to_rgb_tb.sv
